>>> src/bisu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bisu_pkg
// Shared types and constants of the batch integer sorter unit.
// ----------------------------------------------------------------------------
package bisu_pkg;

  // Depth of the queue between the intake and the sorter.
  localparam int QUEUE_DEPTH = 4;

  // Register map: word index of each configuration register.
  localparam int  CFG_ADDR_W     = 3;
  localparam logic REG_DESCENDING = 1'b0;

  // Control bits that travel with each value through the queue.
  typedef struct packed {
    logic keep;      // value goes into the sorter
    logic last;      // closes the batch
    logic overflow;  // batch lost at least one item
  } bisu_ctrl_t;

  typedef enum logic {
    SORT_LOAD,
    SORT_EMIT
  } sort_state_t;

endpackage
`default_nettype wire

>>> src/bisu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bisu_front
// Intake: counts the batch, drops items beyond capacity, tags queue entries.
// ----------------------------------------------------------------------------
module bisu_front #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   last_item,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [VALUE_WIDTH-1:0] q_value,
  output bisu_pkg::bisu_ctrl_t   q_ctrl
);
  import bisu_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0] item_count, item_count_next;
  logic          dropped_flag, dropped_flag_next;
  logic          accept;
  logic          keep;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign keep   = (item_count < CW'(MAX_ITEMS));

  // A dropped item only needs a queue entry when it closes the batch.
  assign q_push           = accept && (keep || last_item);
  assign q_value          = value;
  assign q_ctrl.keep      = keep;
  assign q_ctrl.last      = last_item;
  assign q_ctrl.overflow  = dropped_flag || !keep;

  always_comb begin
    item_count_next   = item_count;
    dropped_flag_next = dropped_flag;
    if (accept) begin
      if (last_item) begin
        item_count_next   = '0;
        dropped_flag_next = 1'b0;
      end else if (keep) begin
        item_count_next = item_count + CW'(1);
      end else begin
        dropped_flag_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count   <= '0;
      dropped_flag <= 1'b0;
    end else begin
      item_count   <= item_count_next;
      dropped_flag <= dropped_flag_next;
    end
  end

endmodule
`default_nettype wire

>>> src/bisu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bisu_queue
// Short first-in first-out queue between the intake and the sorter.
// ----------------------------------------------------------------------------
module bisu_queue #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [VALUE_WIDTH-1:0] wr_value,
  input  bisu_pkg::bisu_ctrl_t   wr_ctrl,
  output logic                   q_full,
  input  logic                   rd_en,
  output logic                   rd_valid,
  output logic [VALUE_WIDTH-1:0] rd_value,
  output bisu_pkg::bisu_ctrl_t   rd_ctrl
);
  import bisu_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_WIDTH-1:0] value_q [QUEUE_DEPTH];
  bisu_ctrl_t             ctrl_q  [QUEUE_DEPTH];
  logic [PW-1:0]          wr_ptr, rd_ptr;
  logic [NW-1:0]          fill;
  logic                   do_wr, do_rd;

  assign q_full   = (fill == NW'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_value = value_q[rd_ptr];
  assign rd_ctrl  = ctrl_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      value_q[wr_ptr] <= wr_value;
      ctrl_q[wr_ptr]  <= wr_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      fill <= fill + NW'(do_wr) - NW'(do_rd);
    end
  end

endmodule
`default_nettype wire

>>> src/bisu_sort.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bisu_sort
// Insertion sorter chain: loads one value a cycle while the queue offers one,
// then shifts the sorted batch out from its head one value a cycle while pop is high.
// ----------------------------------------------------------------------------
module bisu_sort #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          descending,
  input  logic                          q_valid,
  input  logic [VALUE_WIDTH-1:0]        q_value,
  input  bisu_pkg::bisu_ctrl_t          q_ctrl,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [VALUE_WIDTH-1:0] sorted_value,
  output logic                          last_result,
  output logic                          overflow
);
  import bisu_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);

  sort_state_t                   state, state_next;
  logic signed [VALUE_WIDTH-1:0] slot      [MAX_ITEMS];
  logic signed [VALUE_WIDTH-1:0] slot_next [MAX_ITEMS];
  logic [CW-1:0]                 count, count_next;
  logic                          ovf, ovf_next;
  logic [MAX_ITEMS-1:0]          after;
  logic signed [VALUE_WIDTH-1:0] v_in;
  logic                          load, shift;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      SORT_LOAD: begin
        if (q_valid && q_ctrl.last) begin
          state_next = SORT_EMIT;
        end
      end
      SORT_EMIT: begin
        if (pop && count == CW'(1)) begin
          state_next = SORT_LOAD;
        end
      end
      default: state_next = SORT_LOAD;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    q_pop = 1'b0;
    empty = 1'b1;
    unique case (state)
      SORT_LOAD: q_pop = q_valid;
      SORT_EMIT: empty = 1'b0;
      default: begin
        q_pop = 1'b0;
        empty = 1'b1;
      end
    endcase
  end

  assign load         = q_pop && q_ctrl.keep;
  assign shift        = !empty && pop;
  assign v_in         = $signed(q_value);
  assign sorted_value = slot[0];
  assign last_result  = (count == CW'(1));
  assign overflow     = ovf;

  // A slot is "after" the new value when it is empty or must follow it in
  // the selected order. Over the filled prefix this flag is monotonic.
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (CW'(i) >= count) begin
        after[i] = 1'b1;
      end else if (descending) begin
        after[i] = (slot[i] < v_in);
      end else begin
        after[i] = (slot[i] > v_in);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      slot_next[i] = slot[i];
      if (load && after[i]) begin
        if (i > 0 && after[(i > 0) ? i - 1 : 0]) begin
          slot_next[i] = slot[(i > 0) ? i - 1 : 0];
        end else begin
          slot_next[i] = v_in;
        end
      end else if (shift && i < MAX_ITEMS - 1) begin
        slot_next[i] = slot[(i < MAX_ITEMS - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_next = count;
    ovf_next   = ovf;
    if (load) begin
      count_next = count + CW'(1);
    end else if (shift) begin
      count_next = count - CW'(1);
    end
    if (q_pop && q_ctrl.last) begin
      ovf_next = q_ctrl.overflow;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      slot[i] <= slot_next[i];
    end
    ovf <= ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SORT_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

>>> src/batch_integer_sorter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// batch_integer_sorter_unit
// Collects a batch of signed integers and returns it in sorted order.
// ----------------------------------------------------------------------------
// Usage notes.
// Items arrive on a queue-style port: value and last_item are taken at an
// edge where push is high and full is low. The beat with last_item set ends
// the batch. Up to MAX_ITEMS values are kept; later items of the batch are
// dropped and every result of that batch then carries overflow.
// Results leave on a queue-style port: while empty is low the ports show the
// next result of the sorted run, and it is taken at an edge where pop is high.
// The last beat of the sorted run has last_result set.
// The intake takes one item per cycle while full is low. Items wait in a
// four-entry queue and the insertion chain absorbs one value per cycle, so
// intake runs at one item per cycle while the chain is loading. The last
// item passes through the queue into the chain before the first result is
// shown, then one result per cycle while pop stays high. While a batch is
// drained, the next batch collects in the queue until full rises.
// A stalled receiver simply holds the current result in place.
// Sort order is set by the descending register (byte address 0, bit 0);
// write it only while the unit is idle. Reset clears the counts, the queue,
// the sort order and the sorter state, so empty is high after reset.
// ----------------------------------------------------------------------------
module batch_integer_sorter_unit #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // Item port.
  input  logic                            push,
  output logic                            full,
  input  logic signed [VALUE_WIDTH-1:0]   value,
  input  logic                            last_item,
  // Result port.
  output logic                            empty,
  input  logic                            pop,
  output logic signed [VALUE_WIDTH-1:0]   sorted_value,
  output logic                            last_result,
  output logic                            overflow,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bisu_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import bisu_pkg::*;

  logic                   descending;
  logic                   q_full, q_push, q_valid, q_pop;
  logic [VALUE_WIDTH-1:0] fq_value, sq_value;
  bisu_ctrl_t             fq_ctrl, sq_ctrl;

  // The register file holds one bit. Word index is paddr[2]; the low two
  // address bits select a byte and are ignored.
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DESCENDING) begin
      prdata[0] = descending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DESCENDING) begin
      descending <= pwdata[0];
    end
  end

  // Intake classifies each beat as kept or dropped and tags the batch end.
  bisu_front #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .value    (value),
    .last_item(last_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_value  (fq_value),
    .q_ctrl   (fq_ctrl)
  );

  // Decoupling queue lets intake run while the sorter drains a batch.
  bisu_queue #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_value(fq_value),
    .wr_ctrl (fq_ctrl),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_value(sq_value),
    .rd_ctrl (sq_ctrl)
  );

  // Insertion chain does the ordering and feeds the result port directly.
  bisu_sort #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_sort (
    .clk         (clk),
    .rst         (rst),
    .descending  (descending),
    .q_valid     (q_valid),
    .q_value     (sq_value),
    .q_ctrl      (sq_ctrl),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .sorted_value(sorted_value),
    .last_result (last_result),
    .overflow    (overflow)
  );

endmodule
`default_nettype wire

>>> src/bisu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bisu_checker
// Port-level checks of the sorter unit, bound to the top level.
// ----------------------------------------------------------------------------
module bisu_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            empty,
  input logic                            pop,
  input logic signed [VALUE_WIDTH-1:0]   sorted_value,
  input logic                            last_result,
  input logic                            overflow,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic                            pready,
  input logic [bisu_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [31:0]                     pwdata
);
  import bisu_pkg::*;

  // Shadow of the sort order, taken from the write beats.
  logic desc_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_shadow <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DESCENDING) begin
      desc_shadow <= pwdata[0];
    end
  end

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered after reset");

  // A waiting result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(sorted_value)))
    else $error("waiting result changed");

  // Within a run the next result follows at once with the same overflow flag.
  a_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_result) |=> (!empty && overflow == $past(overflow)))
    else $error("sorted run broken");

  // Consecutive results of a run are in the selected order.
  a_order: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_result) |=>
      (desc_shadow ? (sorted_value <= $past(sorted_value))
                   : (sorted_value >= $past(sorted_value))))
    else $error("results out of order");

endmodule

bind batch_integer_sorter_unit bisu_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_bisu_checker (.*);

`default_nettype wire
